>>> hdl/fbd_pkg.sv
package fbd_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int COORD_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W      = $clog2(DEPTH + 1);
	localparam int MUL_W      = COORD_W + DIM_W;
	localparam int DIV_CNT_W  = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;

	localparam int CFG_W      = 8;
	localparam int PIX_W      = 32;
	localparam int POS_W      = 16;
	localparam int BADDR_W    = 16;
	localparam int BYTE_W     = 8;

	localparam logic [PIX_W-1:0] BLACK_OPAQUE = 32'hFF00_0000;
	localparam logic [CFG_W-1:0] RESET_DIM    = 8'd128;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		REQ_SET_PIXEL = 3'd0,
		REQ_GET_PIXEL = 3'd1,
		REQ_BYTE_WR   = 3'd2,
		REQ_BYTE_RD   = 3'd3,
		REQ_FILL      = 3'd4,
		REQ_TAKE      = 3'd5
	} req_t;

	function automatic logic [DIM_W-1:0] active_dim(input logic [CFG_W-1:0] r,
			input int maxv);
		logic [DIM_W-1:0] res;
		if (r == '0) begin
			res = DIM_W'(1);
		end else if (32'(r) > 32'(maxv)) begin
			res = DIM_W'(maxv);
		end else begin
			res = DIM_W'(r);
		end
		return res;
	endfunction

endpackage

>>> hdl/fbd_ram.sv
module fbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> hdl/fbd_div.sv
module fbd_div
	import fbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              done,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic [ADDR_W-1:0] quotient,
	output logic [DIM_W-1:0]  remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    quo_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W-1:0]     dvs_q;
	logic [DIM_W:0]       trial;
	logic [DIM_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign fits  = trial >= (DIM_W + 1)'(dvs_q);
	assign diff  = trial - (DIM_W + 1)'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(ADDR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], fits};
			rem_q <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/framebuffer_dirty_rect_top.sv
// A store of 32-bit pixels with dirty-rectangle tracking, taking one request at a time. After
// reset the block clears the whole store to opaque black before it raises s_axis_tready;
// configuration writes are taken throughout. Set pixel, take-dirty, unused codes and any
// access outside the frame finish once the bound is checked; a get pixel or byte read first
// reads the store, and a byte write also writes the merged word back, then finds its column
// and row for the dirty box with a restoring divider that resolves one quotient bit per cycle.
// Fill writes one word per cycle through the single store port. s_axis_tready rises again in
// the cycle the result appears, and a finished result waits in the output register while the
// next request is taken.
module framebuffer_dirty_rect_top
	import fbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pixel_x[15:0], pixel_y[31:16], color[63:32], byte_address[79:64], byte_value[87:80]
	input  logic [87:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[31:0], dirty_valid[32], dirty_left[39:33], dirty_top[46:40],
	// dirty_width[54:47], dirty_height[62:55], zero[63]
	output logic [63:0] m_axis_tdata
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CALC  = 8'b0000_0100,
		ST_CHECK = 8'b0000_1000,
		ST_RD    = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_FILL  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]   fw_q;
	logic [CFG_W-1:0]   fh_q;
	logic [ADDR_W-1:0]  cnt_q;

	logic [2:0]         req_q;
	logic [POS_W-1:0]   px_q;
	logic [POS_W-1:0]   py_q;
	logic [PIX_W-1:0]   color_q;
	logic [BADDR_W-1:0] baddr_q;
	logic [BYTE_W-1:0]  bval_q;
	logic [DIM_W-1:0]   w_q;
	logic [DIM_W-1:0]   h_q;
	logic [TOT_W-1:0]   total_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               ok_q;

	logic               dflag_q;
	logic [COORD_W-1:0] bl_q;
	logic [COORD_W-1:0] bt_q;
	logic [DIM_W-1:0]   bw_q;
	logic [DIM_W-1:0]   bh_q;

	logic [PIX_W-1:0]   rd_q;
	logic               dv_q;
	logic [6:0]         dl_q;
	logic [6:0]         dt_q;
	logic [7:0]         dw_q;
	logic [7:0]         dh_q;
	logic               out_valid_q;
	logic [63:0]        out_data_q;

	logic               in_fire;
	logic               byte_op;
	logic               ok_now;
	logic               fill_last;
	logic               out_free;

	logic [MUL_W-1:0]              row_base;
	logic [MUL_W:0]                pix_sum;
	logic [2*DIM_W-1:0]            tot_prod;
	logic [ADDR_W+BADDR_W-1:0]     bpix_ext;

	logic               ram_en;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [PIX_W-1:0]   ram_wdata;
	logic [PIX_W-1:0]   ram_rdata;
	logic [PIX_W-1:0]   merged;
	logic [PIX_W-1:0]   byte_shifted;

	logic               div_start;
	logic               div_done;
	logic [ADDR_W-1:0]  div_quo;
	logic [DIM_W-1:0]   div_rem;

	logic               g_en;
	logic [COORD_W-1:0] g_x;
	logic [COORD_W-1:0] g_y;
	logic [DIM_W-1:0]   g_w;
	logic [DIM_W-1:0]   g_h;
	logic [COORD_W-1:0] nx;
	logic [COORD_W-1:0] ny;
	logic [DIM_W:0]     ex;
	logic [DIM_W:0]     ey;
	logic [DIM_W:0]     e1x;
	logic [DIM_W:0]     e2x;
	logic [DIM_W:0]     e1y;
	logic [DIM_W:0]     e2y;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign byte_op   = (req_q == REQ_BYTE_WR) || (req_q == REQ_BYTE_RD);
	assign ok_now    = byte_op ? (32'(baddr_q >> 2) < 32'(total_q)) : ok_q;
	assign fill_last = (TOT_W'(cnt_q) + TOT_W'(1)) == total_q;

	assign row_base = MUL_W'(py_q[COORD_W-1:0]) * MUL_W'(w_q);
	assign pix_sum  = (MUL_W + 1)'(row_base) + (MUL_W + 1)'(px_q[COORD_W-1:0]);
	assign tot_prod = (2 * DIM_W)'(w_q) * (2 * DIM_W)'(h_q);
	assign bpix_ext = (ADDR_W + BADDR_W)'(baddr_q >> 2);

	assign byte_shifted = ram_rdata >> {baddr_q[1:0], 3'b000};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			merged[8*k +: 8] = (baddr_q[1:0] == 2'(k)) ? bval_q : ram_rdata[8*k +: 8];
		end
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = color_q;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = cnt_q;
				ram_wdata = BLACK_OPAQUE;
			end
			ST_CHECK: begin
				if (ok_now) begin
					if (req_q == REQ_SET_PIXEL) begin
						ram_en = 1'b1;
						ram_we = 1'b1;
					end else if ((req_q == REQ_GET_PIXEL) || byte_op) begin
						ram_en = 1'b1;
					end
				end
			end
			ST_RD: begin
				if (req_q == REQ_BYTE_WR) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_wdata = merged;
				end
			end
			ST_FILL: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = cnt_q;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == ST_RD) && (req_q == REQ_BYTE_WR);

	always_comb begin
		g_en = 1'b0;
		g_x  = px_q[COORD_W-1:0];
		g_y  = py_q[COORD_W-1:0];
		g_w  = DIM_W'(1);
		g_h  = DIM_W'(1);
		case (state_q)
			ST_CHECK: begin
				g_en = ok_now && (req_q == REQ_SET_PIXEL);
			end
			ST_DIV: begin
				g_en = div_done;
				g_x  = div_rem[COORD_W-1:0];
				g_y  = div_quo[COORD_W-1:0];
			end
			ST_FILL: begin
				g_en = fill_last;
				g_x  = '0;
				g_y  = '0;
				g_w  = w_q;
				g_h  = h_q;
			end
			default: begin
				g_en = 1'b0;
			end
		endcase
	end

	assign nx  = (g_x < bl_q) ? g_x : bl_q;
	assign ny  = (g_y < bt_q) ? g_y : bt_q;
	assign e1x = (DIM_W + 1)'(bl_q) + (DIM_W + 1)'(bw_q);
	assign e2x = (DIM_W + 1)'(g_x) + (DIM_W + 1)'(g_w);
	assign e1y = (DIM_W + 1)'(bt_q) + (DIM_W + 1)'(bh_q);
	assign e2y = (DIM_W + 1)'(g_y) + (DIM_W + 1)'(g_h);
	assign ex  = (e1x > e2x) ? e1x : e2x;
	assign ey  = (e1y > e2y) ? e1y : e2y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			fw_q        <= RESET_DIM;
			fh_q        <= RESET_DIM;
			dflag_q     <= 1'b1;
			bl_q        <= '0;
			bt_q        <= '0;
			bw_q        <= active_dim(RESET_DIM, MAX_WIDTH);
			bh_q        <= active_dim(RESET_DIM, MAX_HEIGHT);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FRAME_WIDTH) begin
					fw_q <= cfg_data;
				end else if (cfg_index == CFG_FRAME_HEIGHT) begin
					fh_q <= cfg_data;
				end
			end

			if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			if (g_en) begin
				dflag_q <= 1'b1;
				if (!dflag_q) begin
					bl_q <= g_x;
					bt_q <= g_y;
					bw_q <= g_w;
					bh_q <= g_h;
				end else begin
					bl_q <= nx;
					bt_q <= ny;
					bw_q <= DIM_W'(ex - (DIM_W + 1)'(nx));
					bh_q <= DIM_W'(ey - (DIM_W + 1)'(ny));
				end
			end

			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (req_q == REQ_FILL) begin
						state_q <= ST_FILL;
					end else if (ok_now && ((req_q == REQ_GET_PIXEL) || byte_op)) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_DONE;
					end
					if (req_q == REQ_TAKE) begin
						dflag_q <= 1'b0;
					end
				end
				ST_RD: begin
					state_q <= (req_q == REQ_BYTE_WR) ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (fill_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q   <= s_axis_tuser;
			px_q    <= s_axis_tdata[15:0];
			py_q    <= s_axis_tdata[31:16];
			color_q <= s_axis_tdata[63:32];
			baddr_q <= s_axis_tdata[79:64];
			bval_q  <= s_axis_tdata[87:80];
			w_q     <= active_dim(fw_q, MAX_WIDTH);
			h_q     <= active_dim(fh_q, MAX_HEIGHT);
			rd_q    <= '0;
			dv_q    <= 1'b0;
			dl_q    <= '0;
			dt_q    <= '0;
			dw_q    <= '0;
			dh_q    <= '0;
		end

		if (state_q == ST_CALC) begin
			total_q <= tot_prod[TOT_W-1:0];
			ok_q    <= (px_q < POS_W'(w_q)) && (py_q < POS_W'(h_q));
			idx_q   <= byte_op ? bpix_ext[ADDR_W-1:0] : pix_sum[ADDR_W-1:0];
		end

		if ((state_q == ST_CHECK) && (req_q == REQ_TAKE) && dflag_q) begin
			dv_q <= 1'b1;
			dl_q <= 7'(bl_q);
			dt_q <= 7'(bt_q);
			dw_q <= 8'(bw_q);
			dh_q <= 8'(bh_q);
		end

		if (state_q == ST_RD) begin
			if (req_q == REQ_GET_PIXEL) begin
				rd_q <= ram_rdata;
			end else if (req_q == REQ_BYTE_RD) begin
				rd_q <= PIX_W'(byte_shifted[7:0]);
			end
		end

		if ((state_q == ST_DONE) && out_free) begin
			out_data_q <= {1'b0, dh_q, dw_q, dt_q, dl_q, dv_q, rd_q};
		end
	end

	fbd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	fbd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.done      (div_done),
		.dividend  (idx_q),
		.divisor   (w_q),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

endmodule

>>> bench/framebuffer_dirty_rect_top_test.sv
`timescale 1ns / 1ps

module framebuffer_dirty_rect_top_test;
	import fbd_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO    = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI    = 3'd7;
	localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
	localparam int         PHASE_ITEMS     = 66;
	localparam int         TAIL_CYCLES     = 60;

	typedef struct packed {
		logic [7:0]  dirty_height;
		logic [7:0]  dirty_width;
		logic [6:0]  dirty_top;
		logic [6:0]  dirty_left;
		logic        dirty_valid;
		logic [31:0] read_data;
	} fb_reply_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// pixel_x[15:0], pixel_y[31:16], color[63:32], byte_address[79:64], byte_value[87:80]
	logic [87:0] s_axis_tdata;
	// req_type[2:0]
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// read_data[31:0], dirty_valid[32], dirty_left[39:33], dirty_top[46:40],
	// dirty_width[54:47], dirty_height[62:55], zero[63]
	logic [63:0] m_axis_tdata;

	// Shadow copy of the frame and its dirty tracking.
	logic [31:0] shadow_fb [0:DEPTH-1];
	logic [7:0]  width_reg;
	logic [7:0]  height_reg;
	bit          fb_dirty;
	int unsigned box_l, box_t, box_w, box_h;

	fb_reply_t   pixel_replies [$];
	int          req_count [8];
	int          replies_seen;
	int          mismatches;
	int          frame_settings;
	bit          quiet;
	int          stall_left;

	framebuffer_dirty_rect_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned clamp_dim(input logic [7:0] r, input int unsigned lim);
		if (r == 8'd0) begin
			return 1;
		end
		return (r > lim) ? lim : int'(r);
	endfunction

	function automatic int unsigned frame_cols();
		return clamp_dim(width_reg, MAX_WIDTH);
	endfunction

	function automatic int unsigned frame_rows();
		return clamp_dim(height_reg, MAX_HEIGHT);
	endfunction

	task automatic grow_dirty(input int unsigned x, y, w, h);
		int unsigned nx, ny, ex, ey;
		if (!fb_dirty) begin
			box_l = x;
			box_t = y;
			box_w = w;
			box_h = h;
			fb_dirty = 1'b1;
		end else begin
			nx = (x < box_l) ? x : box_l;
			ny = (y < box_t) ? y : box_t;
			ex = (box_l + box_w > x + w) ? box_l + box_w : x + w;
			ey = (box_t + box_h > y + h) ? box_t + box_h : y + h;
			box_l = nx;
			box_t = ny;
			box_w = ex - nx;
			box_h = ey - ny;
		end
	endtask

	task automatic shadow_fb_request(input logic [2:0] req, input logic [15:0] x, y,
			input logic [31:0] col, input logic [15:0] addr, input logic [7:0] bv);
		fb_reply_t   r;
		int unsigned w, h, tot, pix, sh;
		r = '0;
		w = frame_cols();
		h = frame_rows();
		tot = w * h;
		case (req)
			REQ_SET_PIXEL: begin
				if (x < w && y < h) begin
					shadow_fb[y * w + x] = col;
					grow_dirty(x, y, 1, 1);
				end
			end
			REQ_GET_PIXEL: begin
				if (x < w && y < h) begin
					r.read_data = shadow_fb[y * w + x];
				end
			end
			REQ_BYTE_WR: begin
				if (addr < tot * 4) begin
					pix = addr >> 2;
					sh = (addr & 16'd3) * 8;
					shadow_fb[pix][sh +: 8] = bv;
					grow_dirty(pix % w, pix / w, 1, 1);
				end
			end
			REQ_BYTE_RD: begin
				if (addr < tot * 4) begin
					sh = (addr & 16'd3) * 8;
					r.read_data = {24'd0, shadow_fb[addr >> 2][sh +: 8]};
				end
			end
			REQ_FILL: begin
				for (int i = 0; i < tot; i++) begin
					shadow_fb[i] = col;
				end
				grow_dirty(0, 0, w, h);
			end
			REQ_TAKE: begin
				if (fb_dirty) begin
					r.dirty_valid = 1'b1;
					r.dirty_left = box_l[6:0];
					r.dirty_top = box_t[6:0];
					r.dirty_width = box_w[7:0];
					r.dirty_height = box_h[7:0];
					fb_dirty = 1'b0;
				end
			end
			default: begin
			end
		endcase
		pixel_replies.push_back(r);
		req_count[req]++;
	endtask

	task automatic send_request(input logic [2:0] req, input logic [15:0] x, y,
			input logic [31:0] col, input logic [15:0] addr, input logic [7:0] bv);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {bv, addr, col, y, x};
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		shadow_fb_request(req, x, y, col, addr, bv);
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pixel_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH: width_reg = val;
			CFG_FRAME_HEIGHT: height_reg = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [7:0] w, input logic [7:0] h);
		write_register(CFG_FRAME_WIDTH, w);
		write_register(CFG_FRAME_HEIGHT, h);
		frame_settings++;
	endtask

	task automatic random_request();
		logic [2:0]  req;
		logic [15:0] x, y, addr;
		logic [31:0] col;
		logic [7:0]  bv;
		int unsigned w, h, tot, pick, shape;
		w = frame_cols();
		h = frame_rows();
		tot = w * h;
		x = 16'($urandom);
		y = 16'($urandom);
		col = $urandom;
		addr = 16'($urandom);
		bv = 8'($urandom);
		pick = $urandom_range(0, 99);
		shape = $urandom_range(0, 9);
		if (pick < 22) begin
			req = REQ_SET_PIXEL;
		end else if (pick < 40) begin
			req = REQ_GET_PIXEL;
		end else if (pick < 58) begin
			req = REQ_BYTE_WR;
		end else if (pick < 76) begin
			req = REQ_BYTE_RD;
		end else if (pick < 80) begin
			req = (tot <= 1024) ? REQ_FILL : REQ_SET_PIXEL;
		end else if (pick < 97) begin
			req = REQ_TAKE;
		end else begin
			req = pick[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
		end
		if (shape <= 8) begin
			x = 16'($urandom_range(0, w - 1));
			y = 16'($urandom_range(0, h - 1));
			addr = 16'($urandom_range(0, 4 * tot - 1));
		end
		// Just past the edge of the frame or the end of the frame's bytes.
		if (shape == 8) begin
			if ($urandom_range(0, 1) == 1) begin
				x = 16'(w + $urandom_range(0, 2));
			end else begin
				y = 16'(h + $urandom_range(0, 2));
			end
			addr = 16'(4 * tot + $urandom_range(0, 3));
		end
		send_request(req, x, y, col, addr, bv);
	endtask

	task automatic test_reset_state();
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_GET_PIXEL, 16'd0, 16'd0, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_BYTE_RD, 16'($urandom), 16'($urandom), $urandom, 16'hFFFF, 8'($urandom));
		wait_for_replies();
	endtask

	task automatic test_pixel_access();
		send_request(REQ_SET_PIXEL, 16'd127, 16'd127, 32'hFFFF_FFFF, 16'($urandom), 8'($urandom));
		send_request(REQ_SET_PIXEL, 16'd0, 16'd0, 32'h0000_0000, 16'($urandom), 8'($urandom));
		send_request(REQ_GET_PIXEL, 16'd127, 16'd127, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_SET_PIXEL, 16'd128, 16'd5, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_GET_PIXEL, 16'd0, 16'd128, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_GET_PIXEL, 16'hFFFF, 16'hFFFF, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		wait_for_replies();
	endtask

	task automatic test_byte_access();
		send_request(REQ_BYTE_WR, 16'($urandom), 16'($urandom), $urandom, 16'hFFFF, 8'hAA);
		send_request(REQ_BYTE_WR, 16'($urandom), 16'($urandom), $urandom, 16'h0000, 8'h55);
		send_request(REQ_BYTE_RD, 16'($urandom), 16'($urandom), $urandom, 16'hFFFF, 8'($urandom));
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		wait_for_replies();
	endtask

	task automatic test_fill();
		send_request(REQ_FILL, 16'($urandom), 16'($urandom), 32'h1234_5678, 16'($urandom), 8'($urandom));
		send_request(REQ_GET_PIXEL, 16'd64, 16'd64, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		wait_for_replies();
	endtask

	task automatic test_unknown_requests();
		send_request(REQ_SPARE_LO, 16'd1, 16'd1, $urandom, 16'd4, 8'($urandom));
		send_request(REQ_SPARE_HI, 16'd2, 16'd2, $urandom, 16'd8, 8'($urandom));
		wait_for_replies();
	endtask

	// A zero width acts as one column and an oversized height as the maximum.
	task automatic test_frame_size_limits();
		set_frame(8'd0, 8'd255);
		write_register(CFG_INDEX_SPARE, 8'h5A);
		send_request(REQ_SET_PIXEL, 16'd0, 16'd127, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_SET_PIXEL, 16'd1, 16'd0, $urandom, 16'($urandom), 8'($urandom));
		send_request(REQ_BYTE_WR, 16'($urandom), 16'($urandom), $urandom, 16'd511, 8'h3C);
		send_request(REQ_BYTE_WR, 16'($urandom), 16'($urandom), $urandom, 16'd512, 8'hC3);
		send_request(REQ_BYTE_RD, 16'($urandom), 16'($urandom), $urandom, 16'd511, 8'($urandom));
		send_request(REQ_TAKE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom));
		wait_for_replies();
	endtask

	task automatic test_random_traffic();
		logic [7:0] w, h;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w = 8'd16; h = 8'd8; end
				1: begin w = 8'd1; h = 8'd1; end
				2: begin w = 8'd255; h = 8'd3; end
				3: begin w = 8'd5; h = 8'd0; end
				4: begin w = 8'($urandom_range(1, 20)); h = 8'($urandom_range(1, 20)); end
				5: begin w = 8'd128; h = 8'd128; end
				6: begin w = 8'($urandom_range(1, 128)); h = 8'($urandom_range(1, 128)); end
				default: begin w = 8'($urandom_range(1, 12)); h = 8'($urandom_range(1, 12)); end
			endcase
			quiet = (p == 3 || p == 7);
			set_frame(w, h);
			repeat (PHASE_ITEMS) random_request();
			wait_for_replies();
		end
	endtask

	initial begin
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_replies
		fb_reply_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[62:0];
			replies_seen++;
			if (pixel_replies.size() == 0) begin
				if (mismatches < 10) begin
					$display("%0t: reply with no request outstanding, data %h", $realtime,
						m_axis_tdata);
				end
				mismatches++;
			end else begin
				want = pixel_replies.pop_front();
				if (got.read_data !== want.read_data || got.dirty_valid !== want.dirty_valid
						|| got.dirty_left !== want.dirty_left
						|| got.dirty_top !== want.dirty_top
						|| got.dirty_width !== want.dirty_width
						|| got.dirty_height !== want.dirty_height
						|| m_axis_tdata[63] !== 1'b0) begin
					if (mismatches < 10) begin
						$display("%0t: reply %0d expected data %h dirty %b box %0d,%0d %0dx%0d",
							$realtime, replies_seen, want.read_data, want.dirty_valid,
							want.dirty_left, want.dirty_top, want.dirty_width, want.dirty_height);
						$display("%0t: reply %0d got      data %h dirty %b box %0d,%0d %0dx%0d pad %b",
							$realtime, replies_seen, got.read_data, got.dirty_valid,
							got.dirty_left, got.dirty_top, got.dirty_width, got.dirty_height,
							m_axis_tdata[63]);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		quiet = 1'b0;
		replies_seen = 0;
		mismatches = 0;
		frame_settings = 1;
		for (int i = 0; i < 8; i++) begin
			req_count[i] = 0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			shadow_fb[i] = BLACK_OPAQUE;
		end
		width_reg = RESET_DIM;
		height_reg = RESET_DIM;
		fb_dirty = 1'b1;
		box_l = 0;
		box_t = 0;
		box_w = frame_cols();
		box_h = frame_rows();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_pixel_access();
		test_byte_access();
		test_fill();
		test_unknown_requests();
		test_frame_size_limits();
		test_random_traffic();

		quiet = 1'b1;
		wait_for_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d set, %0d get, %0d byte write, %0d byte read, %0d fill, %0d take",
			req_count[REQ_SET_PIXEL], req_count[REQ_GET_PIXEL], req_count[REQ_BYTE_WR],
			req_count[REQ_BYTE_RD], req_count[REQ_FILL], req_count[REQ_TAKE]);
		$display("and %0d unused-code requests over %0d frame sizes; %0d replies, %0d wrong.",
			req_count[REQ_SPARE_LO] + req_count[REQ_SPARE_HI], frame_settings, replies_seen,
			mismatches);
		if (mismatches == 0 && pixel_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/fbd_pkg.sv
hdl/fbd_ram.sv
hdl/fbd_div.sv
hdl/framebuffer_dirty_rect_top.sv
bench/framebuffer_dirty_rect_top_test.sv
